// ===== rtl/wtwm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtwm_pkg
// Shared types, constants and helper functions of the weekly time window
// matcher.
// ----------------------------------------------------------------------------
package wtwm_pkg;

  // table geometry
  localparam int MAX_WINDOWS = 8;
  localparam int WIN_IDX_W   = $clog2(MAX_WINDOWS);
  localparam int WIN_CNT_W   = $clog2(MAX_WINDOWS + 1);
  localparam int TOD_W       = 17;

  // time constants
  localparam logic [TOD_W-1:0] SECS_DAY  = 17'd86400;
  localparam logic [TOD_W-1:0] SECS_HOUR = 17'd3600;
  localparam logic [TOD_W-1:0] SECS_MIN  = 17'd60;

  // seconds per day = 2^7 * 675; the odd part is divided by reciprocal
  localparam int              DAY_SHIFT = 7;
  localparam logic [9:0]      DAY_ODD   = 10'd675;
  localparam int              RECIP_SH  = 35;
  // floor(2^35 / 675), estimate is low by at most one
  localparam logic [25:0]     RECIP     = 26'd50903316;
  localparam logic [10:0]     REM_LIMIT = 11'd1350;

  // epoch day 0 was a thursday
  localparam logic [15:0]     EPOCH_DAY = 16'd4;
  localparam logic [2:0]      DAYS_WEEK = 3'd7;

  // input commands
  typedef enum logic [1:0] {
    CMD_WRITE       = 2'd0,
    CMD_CHECK_TS    = 2'd1,
    CMD_CHECK_CLOCK = 2'd2,
    CMD_NONE        = 2'd3
  } command_t;

  // configuration register indexes
  typedef enum logic {
    REG_WEEKDAY_MASK = 1'b0,
    REG_WINDOW_COUNT = 1'b1
  } reg_index_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic div_step;
    logic rem_step;
    logic fix_step;
    logic scan_step;
    logic load_out;
  } wtwm_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } wtwm_status_t;

  // seconds of day from hour and minute fields, no wrap
  function automatic logic [TOD_W-1:0] clock_secs(input logic [4:0] h, input logic [5:0] m);
    clock_secs = TOD_W'(TOD_W'(h) * SECS_HOUR) + TOD_W'(TOD_W'(m) * SECS_MIN);
  endfunction

  // value mod 7 using 8 == 1 (mod 7) on octal digits
  function automatic logic [2:0] mod7_u16(input logic [15:0] v);
    logic [5:0] s1;
    logic [3:0] s2;
    s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12]) + 6'(v[15]);
    s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
    if (s2 >= 4'(DAYS_WEEK)) begin
      s2 = s2 - 4'(DAYS_WEEK);
    end
    mod7_u16 = s2[2:0];
  endfunction

endpackage

// ===== rtl/wtwm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtwm_if
// Valid/ready channels of the matcher: request beats in, result beats out.
// ----------------------------------------------------------------------------
interface wtwm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [2:0] window_index;
  logic [4:0] on_hour;
  logic [5:0] on_minute;
  logic [4:0] off_hour;
  logic [5:0] off_minute;
  logic [31:0] timestamp;
  logic [5:0] minute;
  logic [4:0] hour;
  logic [2:0] weekday;

  modport source (
    output valid, command, window_index, on_hour, on_minute, off_hour, off_minute,
           timestamp, minute, hour, weekday,
    input  ready
  );
  modport sink (
    input  valid, command, window_index, on_hour, on_minute, off_hour, off_minute,
           timestamp, minute, hour, weekday,
    output ready
  );
endinterface

interface wtwm_rsp_if;
  logic valid;
  logic ready;
  logic scheduled;

  modport source (output valid, scheduled, input ready);
  modport sink (input valid, scheduled, output ready);
endinterface

// ===== rtl/wtwm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtwm_ctrl
// Sequencer of the matcher: accepts a beat, steps the day division for
// timestamp checks, walks the window table and hands off the result.
// ----------------------------------------------------------------------------
module wtwm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic [1:0]            req_command,
  output logic                  req_ready,
  output wtwm_pkg::wtwm_cmd_t   cmd,
  input  wtwm_pkg::wtwm_status_t status
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_REM  = 6'b000100,
    S_FIX  = 6'b001000,
    S_SCAN = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req_command == wtwm_pkg::CMD_CHECK_TS) begin
            state_next = S_DIV;
          end else if (req_command == wtwm_pkg::CMD_CHECK_CLOCK) begin
            state_next = S_SCAN;
          end
        end
      end
      S_DIV:  state_next = S_REM;
      S_REM:  state_next = S_FIX;
      S_FIX:  state_next = S_SCAN;
      S_SCAN: begin
        if (status.scan_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath commands
  always_comb begin
    cmd.accept    = accept;
    cmd.div_step  = (state == S_DIV);
    cmd.rem_step  = (state == S_REM);
    cmd.fix_step  = (state == S_FIX);
    cmd.scan_step = (state == S_SCAN);
    cmd.load_out  = (state == S_DONE) && status.out_free;
  end

endmodule

// ===== rtl/wtwm_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtwm_dp
// Datapath of the matcher: window table, timestamp to weekday and time of
// day split, one window compare per cycle and the result register.
// ----------------------------------------------------------------------------
module wtwm_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  wtwm_pkg::wtwm_cmd_t                   cmd,
  output wtwm_pkg::wtwm_status_t                status,
  input  logic [6:0]                            weekday_mask,
  input  logic [3:0]                            window_count,
  input  logic [1:0]                            command,
  input  logic [wtwm_pkg::WIN_IDX_W-1:0]        window_index,
  input  logic [4:0]                            on_hour,
  input  logic [5:0]                            on_minute,
  input  logic [4:0]                            off_hour,
  input  logic [5:0]                            off_minute,
  input  logic [31:0]                           timestamp,
  input  logic [5:0]                            minute,
  input  logic [4:0]                            hour,
  input  logic [2:0]                            weekday,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic                                  scheduled
);

  localparam int TW = wtwm_pkg::TOD_W;
  localparam int CW = wtwm_pkg::WIN_CNT_W;

  // window table
  logic [TW-1:0] tbl_open  [wtwm_pkg::MAX_WINDOWS];
  logic [TW-1:0] tbl_close [wtwm_pkg::MAX_WINDOWS];

  // division and check registers
  logic [24:0]    ts_q1;
  logic [6:0]     ts_lo;
  logic [15:0]    est;
  logic [10:0]    rem;
  logic [TW-1:0]  tod;
  logic [2:0]     day;
  logic [CW-1:0]  scan_cnt;
  logic           hit;

  logic [50:0]    prod;
  logic [24:0]    back;
  logic [TW-1:0]  clk_secs;
  logic [TW-1:0]  clk_tod;
  logic [CW-1:0]  limit;
  logic           cur_hit;
  logic           day_ok;
  logic [10:0]    rem_fix;
  logic [15:0]    days;

  // table writes, reset to all zeros
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < wtwm_pkg::MAX_WINDOWS; i++) begin
        tbl_open[i]  <= '0;
        tbl_close[i] <= '0;
      end
    end else if (cmd.accept && command == wtwm_pkg::CMD_WRITE) begin
      tbl_open[window_index]  <= wtwm_pkg::clock_secs(on_hour, on_minute);
      tbl_close[window_index] <= wtwm_pkg::clock_secs(off_hour, off_minute);
    end
  end

  // clock field check: time of day wraps once at most
  assign clk_secs = wtwm_pkg::clock_secs(hour, minute);
  assign clk_tod  = (clk_secs >= wtwm_pkg::SECS_DAY) ? clk_secs - wtwm_pkg::SECS_DAY
                                                     : clk_secs;

  // reciprocal estimate and remainder of the odd day factor
  assign prod    = 51'(ts_q1) * 51'(wtwm_pkg::RECIP);
  assign back    = 25'(25'(est) * 25'(wtwm_pkg::DAY_ODD));
  assign rem_fix = rem - 11'(wtwm_pkg::DAY_ODD);
  assign days    = (rem >= 11'(wtwm_pkg::DAY_ODD)) ? est + 16'd1 : est;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ts_q1 <= timestamp[31:wtwm_pkg::DAY_SHIFT];
      ts_lo <= timestamp[wtwm_pkg::DAY_SHIFT-1:0];
      tod   <= clk_tod;
      day   <= weekday;
    end else if (cmd.div_step) begin
      est <= prod[wtwm_pkg::RECIP_SH +: 16];
    end else if (cmd.rem_step) begin
      rem <= 11'(ts_q1 - back);
    end else if (cmd.fix_step) begin
      if (rem >= 11'(wtwm_pkg::DAY_ODD)) begin
        tod <= {rem_fix[9:0], ts_lo};
      end else begin
        tod <= {rem[9:0], ts_lo};
      end
      day <= wtwm_pkg::mod7_u16(days + wtwm_pkg::EPOCH_DAY);
    end
  end

  // window walk, one entry per cycle
  assign limit   = (window_count > CW'(wtwm_pkg::MAX_WINDOWS)) ? CW'(wtwm_pkg::MAX_WINDOWS)
                                                               : CW'(window_count);
  assign cur_hit = (tod >= tbl_open[scan_cnt[wtwm_pkg::WIN_IDX_W-1:0]]) &&
                   (tod <= tbl_close[scan_cnt[wtwm_pkg::WIN_IDX_W-1:0]]);
  assign status.scan_done = hit || (scan_cnt == limit);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      scan_cnt <= '0;
      hit      <= 1'b0;
    end else if (cmd.scan_step && !status.scan_done) begin
      scan_cnt <= scan_cnt + CW'(1);
      hit      <= cur_hit;
    end
  end

  // result register
  assign day_ok          = (day != wtwm_pkg::DAYS_WEEK) && weekday_mask[day];
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      scheduled <= hit && day_ok;
    end
  end

  // checks
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> scan_cnt <= limit)
    else $error("window walk ran past the active count");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rem_step |=> rem < wtwm_pkg::REM_LIMIT)
    else $error("reciprocal estimate off by more than one");

  a_tod_range: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> tod < wtwm_pkg::SECS_DAY)
    else $error("time of day out of range during window walk");

  a_day_range: assert property (@(posedge clk) disable iff (rst)
    cmd.fix_step |=> day < wtwm_pkg::DAYS_WEEK)
    else $error("derived weekday out of range");

endmodule

// ===== rtl/weekly_time_window_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weekly_time_window_matcher
// Top level: configuration registers, sequencer and datapath of the weekly
// time window matcher.
// ----------------------------------------------------------------------------
// A window write gives no result beat. A clock field check gives its result
// beat after the datapath has walked at most n table windows, where n is the
// active window count (capped at 8), since the datapath compares one table
// window per cycle and stops at the first hit; a result beat still waiting on
// the output register holds off the handoff until it is taken. A timestamp
// check first splits the timestamp into day number and time of day, in the
// steps reciprocal multiply, remainder and correction.
// The block takes one item at a time, but a waiting result beat does not hold
// off the next request once the sequencer has handed it to the output
// register.
module weekly_time_window_matcher (
  input  logic         clk,
  input  logic         rst,
  wtwm_req_if.sink     request,
  wtwm_rsp_if.source   result,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  wtwm_pkg::wtwm_cmd_t    cmd;
  wtwm_pkg::wtwm_status_t status;

  logic [6:0] weekday_mask;
  logic [3:0] window_count;
  logic       cfg_write;

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      weekday_mask <= '0;
      window_count <= '0;
    end else if (cfg_write) begin
      case (paddr[2])
        wtwm_pkg::REG_WEEKDAY_MASK: weekday_mask <= pwdata[6:0];
        wtwm_pkg::REG_WINDOW_COUNT: window_count <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[2])
      wtwm_pkg::REG_WEEKDAY_MASK: prdata = {25'd0, weekday_mask};
      wtwm_pkg::REG_WINDOW_COUNT: prdata = {28'd0, window_count};
      default:                    prdata = '0;
    endcase
  end

  wtwm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (request.valid),
    .req_command (request.command),
    .req_ready   (request.ready),
    .cmd         (cmd),
    .status      (status)
  );

  wtwm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .weekday_mask (weekday_mask),
    .window_count (window_count),
    .command      (request.command),
    .window_index (request.window_index),
    .on_hour      (request.on_hour),
    .on_minute    (request.on_minute),
    .off_hour     (request.off_hour),
    .off_minute   (request.off_minute),
    .timestamp    (request.timestamp),
    .minute       (request.minute),
    .hour         (request.hour),
    .weekday      (request.weekday),
    .out_ready    (result.ready),
    .out_valid    (result.valid),
    .scheduled    (result.scheduled)
  );

endmodule
